// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL of the box query block.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define OBB_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define OBB_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/obb_pkg.sv =====
// Types and constants of the oriented box query block.
// No dependencies; used by obb_point_query.
package obb_pkg;

   localparam int CFG_W = 48;
   localparam int CSR_AW = 3;

   localparam logic [CSR_AW-1:0] CSR_CENTER  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_AXIS0   = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_AXIS1   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_AXIS2   = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_EXTENTS = 3'd4;

   localparam logic [CFG_W-1:0] RST_CENTER  = 48'd0;
   localparam logic [CFG_W-1:0] RST_AXIS0   = 48'd16384;
   localparam logic [CFG_W-1:0] RST_AXIS1   = 48'd1073741824;
   localparam logic [CFG_W-1:0] RST_AXIS2   = 48'd70368744177664;
   localparam logic [CFG_W-1:0] RST_EXTENTS = 48'd1099528405248;

   localparam logic [1:0] FUNC_CLOSEST = 2'd0;
   localparam logic [1:0] FUNC_SUPPORT = 2'd1;
   localparam logic [1:0] FUNC_PROJECT = 2'd2;
   localparam logic [1:0] FUNC_FACE    = 2'd3;

   localparam logic [2:0] FACE_NONE   = 3'd0;
   localparam logic [2:0] FACE_A0_POS = 3'd1;
   localparam logic [2:0] FACE_A1_POS = 3'd2;
   localparam logic [2:0] FACE_A1_NEG = 3'd3;
   localparam logic [2:0] FACE_A2_POS = 3'd4;
   localparam logic [2:0] FACE_A0_NEG = 3'd5;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] vec_x;
      logic signed [15:0] vec_y;
      logic signed [15:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic signed [15:0] proj_min;
      logic signed [15:0] proj_max;
      logic [2:0]         face_id;
   } rsp_type;

endpackage

// ===== rtl/obb_point_query.sv =====
// Oriented box point query: closest point, support point, projection, face.
// Depends on obb_pkg and assert_macros.svh.
//
//   channel   ports                            direction  transaction when
//   request   start, busy, req_data            in         start && !busy
//   response  rsp_valid, rsp_data              out        rsp_valid (one cycle)
//   csr       csr_we, csr_addr, csr_wdata      in         csr_we
//
// Five register stages: input capture, dot products, clamp/sign/magnitude,
// second products (axis times clamp, extent cross products), final sums.
// rsp_valid and rsp_data are registered in the final sums stage; one transaction
// per cycle, back to back. busy is always low: the pipeline has no stall path
// since the receiver cannot hold responses off. Synchronous reset clears valid
// bits and loads the box registers with the unit box at the origin.
module obb_point_query #(
   parameter int COORD_WIDTH    = 16,
   parameter int AXIS_FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  obb_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output obb_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [obb_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [obb_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int F  = AXIS_FRAC_BITS;
   // projection path width: c.v shifted by F, or the extent sum
   localparam int PW = (((34 + F) > 52) ? (34 + F) : 52) + 2;
   localparam logic signed [35:0]   HALF_F  = 36'sd1 <<< (F - 1);
   localparam logic signed [PW-1:0] HALF_P  = PW'(1) <<< (F + 7);
   localparam logic signed [PW-1:0] SAT_HI  = (PW'(1) <<< (COORD_WIDTH - 1)) - PW'(1);
   localparam logic signed [PW-1:0] SAT_LO  = -SAT_HI - PW'(1);

   function automatic logic [15:0] sat16(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] y;
      y = x;
      if (x > SAT_HI) y = SAT_HI;
      if (x < SAT_LO) y = SAT_LO;
      return y[15:0];
   endfunction

   // ---------------- box registers ----------------
   logic [obb_pkg::CFG_W-1:0] center_ff, axis0_ff, axis1_ff, axis2_ff, ext_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= obb_pkg::RST_CENTER;
         axis0_ff  <= obb_pkg::RST_AXIS0;
         axis1_ff  <= obb_pkg::RST_AXIS1;
         axis2_ff  <= obb_pkg::RST_AXIS2;
         ext_ff    <= obb_pkg::RST_EXTENTS;
      end else if (csr_we) begin
         unique case (csr_addr)
            obb_pkg::CSR_CENTER:  center_ff <= csr_wdata;
            obb_pkg::CSR_AXIS0:   axis0_ff  <= csr_wdata;
            obb_pkg::CSR_AXIS1:   axis1_ff  <= csr_wdata;
            obb_pkg::CSR_AXIS2:   axis2_ff  <= csr_wdata;
            obb_pkg::CSR_EXTENTS: ext_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // unpacked slots; user changes registers only while pipe empty; not enforced
   logic signed [15:0] ax [3][3];
   logic signed [15:0] cen [3];
   logic [15:0]        ext [3];
   logic [2:0]         ext_nz;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ax[0][k] = axis0_ff[16*k +: 16];
         ax[1][k] = axis1_ff[16*k +: 16];
         ax[2][k] = axis2_ff[16*k +: 16];
         cen[k]   = center_ff[16*k +: 16];
         ext[k]   = ext_ff[16*k +: 16];
         ext_nz[k] = (ext_ff[16*k +: 16] != 16'd0);
      end
   end

   assign busy = 1'b0;
   wire accept = start && !busy;

   // ---------------- stage A: capture, v - c ----------------
   logic               a_vld_ff;
   logic [1:0]         a_func_ff;
   logic signed [15:0] a_v_ff [3];
   logic signed [16:0] a_d_ff [3];

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= accept;
   end

   always_ff @(posedge clock) begin
      a_func_ff <= req_data.func;
      a_v_ff[0] <= req_data.vec_x;
      a_v_ff[1] <= req_data.vec_y;
      a_v_ff[2] <= req_data.vec_z;
      a_d_ff[0] <= 17'(req_data.vec_x) - 17'(cen[0]);
      a_d_ff[1] <= 17'(req_data.vec_y) - 17'(cen[1]);
      a_d_ff[2] <= 17'(req_data.vec_z) - 17'(cen[2]);
   end

   // ---------------- stage B: dot products ----------------
   logic               b_vld_ff;
   logic [1:0]         b_func_ff;
   logic signed [34:0] b_dotd_ff [3];
   logic signed [33:0] b_dotv_ff [3];
   logic signed [33:0] b_cv_ff;

   logic signed [32:0] pd [3][3];
   logic signed [31:0] pv [3][3];
   logic signed [31:0] pc [3];
   logic signed [34:0] dotd_in [3];
   logic signed [33:0] dotv_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            pd[i][k] = a_d_ff[k] * ax[i][k];
            pv[i][k] = a_v_ff[k] * ax[i][k];
         end
         dotd_in[i] = 35'(pd[i][0]) + 35'(pd[i][1]) + 35'(pd[i][2]);
         dotv_in[i] = 34'(pv[i][0]) + 34'(pv[i][1]) + 34'(pv[i][2]);
         pc[i] = a_v_ff[i] * cen[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_vld_ff;
   end

   always_ff @(posedge clock) begin
      b_func_ff <= a_func_ff;
      b_dotd_ff <= dotd_in;
      b_dotv_ff <= dotv_in;
      b_cv_ff   <= 34'(pc[0]) + 34'(pc[1]) + 34'(pc[2]);
   end

   // ---------------- stage C: clamp or sign, magnitudes ----------------
   logic               c_vld_ff;
   logic [1:0]         c_func_ff;
   logic signed [17:0] c_m_ff [3];
   logic [32:0]        c_mag_ff [3];
   logic [2:0]         c_pos_ff, c_neg_ff;
   logic signed [33:0] c_cv_ff;

   logic signed [17:0] m_in [3];
   logic [32:0]        mag_in [3];
   logic [2:0]         pos_in, neg_in;
   logic signed [35:0] rnd_d, e36;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = !b_dotv_ff[i][33] && (b_dotv_ff[i] != 34'sd0);
         neg_in[i] = b_dotv_ff[i][33];
         mag_in[i] = neg_in[i] ? 33'(-b_dotv_ff[i]) : 33'(b_dotv_ff[i]);
         rnd_d = (36'(b_dotd_ff[i]) + HALF_F) >>> F;
         e36   = 36'(ext[i]);
         if (b_func_ff == obb_pkg::FUNC_CLOSEST) begin
            if (rnd_d > e36)       m_in[i] = 18'(e36);
            else if (rnd_d < -e36) m_in[i] = 18'(-e36);
            else                   m_in[i] = 18'(rnd_d);
         end else begin
            if (pos_in[i])      m_in[i] = 18'(e36);
            else if (neg_in[i]) m_in[i] = 18'(-e36);
            else                m_in[i] = 18'sd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else       c_vld_ff <= b_vld_ff;
   end

   always_ff @(posedge clock) begin
      c_func_ff <= b_func_ff;
      c_m_ff    <= m_in;
      c_mag_ff  <= mag_in;
      c_pos_ff  <= pos_in;
      c_neg_ff  <= neg_in;
      c_cv_ff   <= b_cv_ff;
   end

   // ---------------- stage D: second products ----------------
   logic               d_vld_ff;
   logic [1:0]         d_func_ff;
   logic signed [33:0] d_am_ff [3][3];
   logic [48:0]        d_em_ff [3];
   logic [48:0]        d_x10_ff, d_x01_ff, d_x20_ff, d_x02_ff, d_x21_ff, d_x12_ff;
   logic [2:0]         d_pos_ff, d_neg_ff;
   logic signed [33:0] d_cv_ff;

   logic signed [33:0] am_in [3][3];
   logic [48:0]        em_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++)
            am_in[i][k] = ax[i][k] * c_m_ff[i];
         em_in[i] = c_mag_ff[i] * ext[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else       d_vld_ff <= c_vld_ff;
   end

   always_ff @(posedge clock) begin
      d_func_ff <= c_func_ff;
      d_am_ff   <= am_in;
      d_em_ff   <= em_in;
      d_x10_ff  <= c_mag_ff[1] * ext[0];
      d_x01_ff  <= c_mag_ff[0] * ext[1];
      d_x20_ff  <= c_mag_ff[2] * ext[0];
      d_x02_ff  <= c_mag_ff[0] * ext[2];
      d_x21_ff  <= c_mag_ff[2] * ext[1];
      d_x12_ff  <= c_mag_ff[1] * ext[2];
      d_pos_ff  <= c_pos_ff;
      d_neg_ff  <= c_neg_ff;
      d_cv_ff   <= c_cv_ff;
   end

   // ---------------- stage E: sums, rounding, face pick ----------------
   logic             rsp_valid_ff;
   obb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic signed [35:0]   acc, rnd_a;
   logic [15:0]          pt [3];
   logic signed [PW-1:0] cvf, esum, lo, hi;
   logic [2:0]           cand;
   logic                 take1, take2, have1, best_is1;
   logic [2:0]           face;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc   = 36'(d_am_ff[0][k]) + 36'(d_am_ff[1][k]) + 36'(d_am_ff[2][k]);
         rnd_a = (acc + HALF_F) >>> F;
         pt[k] = sat16(PW'(rnd_a) + PW'(cen[k]));
      end

      // corner range: c.v * 2^F +/- sum e_i |a_i . v|
      cvf  = PW'(d_cv_ff) <<< F;
      esum = PW'(d_em_ff[0]) + PW'(d_em_ff[1]) + PW'(d_em_ff[2]);
      lo   = (cvf - esum + HALF_P) >>> (F + 8);
      hi   = (cvf + esum + HALF_P) >>> (F + 8);

      // face: strict compare of |a_i . v|/e_i by cross products, ties keep earlier
      cand     = ext_nz & (d_pos_ff | d_neg_ff);
      take1    = cand[1] && (!cand[0] || (d_x10_ff > d_x01_ff));
      have1    = cand[0] || cand[1];
      best_is1 = take1;
      take2    = cand[2] && (!have1 ||
                 (best_is1 ? (d_x21_ff > d_x12_ff) : (d_x20_ff > d_x02_ff)));
      if (take2)
         face = d_pos_ff[2] ? obb_pkg::FACE_A2_POS : obb_pkg::FACE_NONE;
      else if (best_is1)
         face = d_pos_ff[1] ? obb_pkg::FACE_A1_POS : obb_pkg::FACE_A1_NEG;
      else if (cand[0])
         face = d_pos_ff[0] ? obb_pkg::FACE_A0_POS : obb_pkg::FACE_A0_NEG;
      else
         face = obb_pkg::FACE_NONE;

      rsp_data_in = '0;
      case (d_func_ff) inside
         obb_pkg::FUNC_CLOSEST, obb_pkg::FUNC_SUPPORT: begin
            rsp_data_in.point_x = pt[0];
            rsp_data_in.point_y = pt[1];
            rsp_data_in.point_z = pt[2];
         end
         obb_pkg::FUNC_PROJECT: begin
            rsp_data_in.proj_min = sat16(lo);
            rsp_data_in.proj_max = sat16(hi);
         end
         default: rsp_data_in.face_id = face;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= d_vld_ff;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   `include "assert_macros.svh"

   // a face response leaves point_x and the range fields clear
   wire face_only = (rsp_data.point_x == 16'sd0) && (rsp_data.proj_min == 16'sd0) &&
                    (rsp_data.proj_max == 16'sd0);
   wire face_set  = rsp_valid && (rsp_data.face_id != obb_pkg::FACE_NONE);

   `OBB_ASSERT_RST(a_latency, clock, reset, accept |-> ##5 rsp_valid, "response latency")
   `OBB_ASSERT_RST(a_face_range, clock, reset, rsp_valid |-> (rsp_data.face_id <= 3'd5), "face id")
   `OBB_ASSERT_RST(a_face_excl, clock, reset, face_set |-> face_only, "face with other fields set")
   `OBB_ASSERT_ALL(a_reset_flush, clock, reset |=> !rsp_valid, "response after reset")

endmodule
